// ===== design/pump_power_ramp_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Pump power ramp controller assertion macros
// Shared wrappers for the concurrent checks of the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef PUMP_POWER_RAMP_CONTROLLER_TOP_MACROS_SVH
`define PUMP_POWER_RAMP_CONTROLLER_TOP_MACROS_SVH

// Check that is switched off while reset is high.
`define PPR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that also holds during reset.
`define PPR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// Pump power ramp controller package
// Types, codes and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package ppr_pkg;

   localparam int unsigned PUMP_COUNT = 3;
   localparam int unsigned PTR_W      = (PUMP_COUNT > 1) ? $clog2(PUMP_COUNT) : 1;

   localparam logic [9:0] CEIL_LIMIT      = 10'd1000;
   localparam logic [9:0] MAX_POWER_RESET = 10'd700;
   localparam logic [9:0] RAMP_STEP_RESET = 10'd30;
   localparam logic [7:0] EN_DELAY_RESET  = 8'd10;

   typedef enum logic [1:0] {
      CMD_SET_MODE  = 2'd0,
      CMD_SET_POWER = 2'd1,
      CMD_TICK      = 2'd2,
      CMD_NONE      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_STOP = 2'd0,
      MODE_FWD  = 2'd1,
      MODE_REV  = 2'd2,
      MODE_BAD  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_MAX_POWER = 2'd0,
      REG_RAMP_STEP = 2'd1,
      REG_EN_DELAY  = 2'd2,
      REG_UNUSED    = 2'd3
   } reg_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // capture the request word and set the pump pointer
      logic fire;   // update the current pump and load the result register
   } ppr_ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;  // result register can take a new word this cycle
      logic is_last;   // the word about to be produced ends this request
   } ppr_stat_type;

endpackage

// ===== design/ppr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pump power ramp controller sequencer
// Accepts a request word and steps the datapath through the pumps it touches.
// ----------------------------------------------------------------------------
`include "pump_power_ramp_controller_top_macros.svh"

module ppr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ppr_pkg::ppr_stat_type stat,
   output ppr_pkg::ppr_ctl_type  ctl
);
   import ppr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.out_free && stat.is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_RUN: begin
            ctl.fire = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `PPR_ASSERT_ALWAYS(a_load_fire_apart, !(ctl.load && ctl.fire), "load and fire together")
   `PPR_ASSERT(a_last_ends_run, ctl.fire && stat.is_last |=> state_ff == ST_IDLE,
               "sequencer kept running after the final word")
   `PPR_ASSERT(a_load_starts_run, ctl.load |=> state_ff == ST_RUN && !req_ready,
               "request taken without starting a run")

endmodule

// ===== design/ppr_datapath.sv =====
// ----------------------------------------------------------------------------
// Pump power ramp controller datapath
// Per-pump state, configuration registers, update logic and result register.
// ----------------------------------------------------------------------------
`include "pump_power_ramp_controller_top_macros.svh"

module ppr_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ppr_pkg::ppr_ctl_type  ctl,
   output ppr_pkg::ppr_stat_type stat,
   input  logic [1:0]            req_cmd,
   input  logic [3:0]            req_pump_index,
   input  logic [1:0]            req_new_mode,
   input  logic [9:0]            req_power_permil,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [9:0]            csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_unit,
   output logic                  rsp_accepted,
   output logic [1:0]            rsp_mode_now,
   output logic [9:0]            rsp_target_now,
   output logic [9:0]            rsp_drive_level,
   output logic                  rsp_enable_line,
   output logic                  rsp_reverse_line,
   output logic                  rsp_last
);
   import ppr_pkg::*;

   // Configuration registers.
   logic [9:0] max_power_ff;
   logic [9:0] ramp_step_ff;
   logic [7:0] en_delay_ff;

   // Per-pump state.
   mode_type   mode_ff   [PUMP_COUNT];
   logic [7:0] delay_ff  [PUMP_COUNT];
   logic [9:0] target_ff [PUMP_COUNT];
   logic [9:0] out_ff    [PUMP_COUNT];
   logic       en_ff     [PUMP_COUNT];
   logic       dir_ff    [PUMP_COUNT];

   // Captured request word and pump pointer.
   cmd_type          q_cmd_ff;
   logic [3:0]       q_idx_ff;
   mode_type         q_mode_ff;
   logic [9:0]       q_pwr_ff;
   logic [PTR_W-1:0] ptr_ff;

   // Result register.
   logic       rsp_valid_ff;
   logic [3:0] rsp_unit_ff;
   logic       rsp_acc_ff;
   logic [1:0] rsp_mode_ff;
   logic [9:0] rsp_target_ff;
   logic [9:0] rsp_drive_ff;
   logic       rsp_en_ff;
   logic       rsp_dir_ff;
   logic       rsp_last_ff;

   logic             in_range;
   logic [PTR_W-1:0] sel;
   mode_type         cur_mode;
   logic [7:0]       cur_delay;
   logic [9:0]       cur_target;
   logic [9:0]       cur_out;
   logic             cur_en;
   logic             cur_dir;

   mode_type   mode_in;
   logic [7:0] delay_in;
   logic [9:0] target_in;
   logic [9:0] out_in;
   logic       en_in;
   logic       dir_in;
   logic       acc_in;

   logic [7:0] delay_dec;
   logic [9:0] ceil_val;
   logic [9:0] tgt_clamp;
   logic       ramp_up;
   logic [9:0] diff;
   logic [9:0] mag;
   logic [9:0] ramp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_power_ff <= MAX_POWER_RESET;
         ramp_step_ff <= RAMP_STEP_RESET;
         en_delay_ff  <= EN_DELAY_RESET;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_MAX_POWER: max_power_ff <= csr_data;
            REG_RAMP_STEP: ramp_step_ff <= csr_data;
            REG_EN_DELAY:  en_delay_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         q_cmd_ff  <= cmd_type'(req_cmd);
         q_idx_ff  <= req_pump_index;
         q_mode_ff <= mode_type'(req_new_mode);
         q_pwr_ff  <= req_power_permil;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (ctl.load) begin
         ptr_ff <= (cmd_type'(req_cmd) == CMD_TICK) ? '0 : req_pump_index[PTR_W-1:0];
      end else if (ctl.fire) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
   end

   // A tick always addresses a real pump; other commands must check the index.
   assign in_range = (q_cmd_ff == CMD_TICK) ||
                     ((q_cmd_ff != CMD_NONE) && ({1'b0, q_idx_ff} < 5'(PUMP_COUNT)));
   assign sel      = in_range ? ptr_ff : '0;

   assign cur_mode   = mode_ff[sel];
   assign cur_delay  = delay_ff[sel];
   assign cur_target = target_ff[sel];
   assign cur_out    = out_ff[sel];
   assign cur_en     = en_ff[sel];
   assign cur_dir    = dir_ff[sel];

   assign delay_dec = (cur_delay != 8'd0) ? cur_delay - 8'd1 : 8'd0;
   assign ceil_val  = (max_power_ff > CEIL_LIMIT) ? CEIL_LIMIT : max_power_ff;
   assign tgt_clamp = (cur_target > ceil_val) ? ceil_val : cur_target;
   assign ramp_up   = tgt_clamp > cur_out;
   assign diff      = ramp_up ? tgt_clamp - cur_out : cur_out - tgt_clamp;
   assign mag       = (diff > ramp_step_ff) ? ramp_step_ff : diff;
   assign ramp_out  = ramp_up ? cur_out + mag : cur_out - mag;

   always_comb begin
      mode_in   = cur_mode;
      delay_in  = cur_delay;
      target_in = cur_target;
      out_in    = cur_out;
      en_in     = cur_en;
      dir_in    = cur_dir;
      acc_in    = 1'b0;
      case (q_cmd_ff)
         CMD_TICK: begin
            acc_in   = 1'b1;
            delay_in = delay_dec;
            if (cur_mode == MODE_STOP) begin
               if (delay_dec == 8'd0) begin
                  dir_in = 1'b0;
               end
            end else if (delay_dec == 8'd0) begin
               if (!cur_en) begin
                  // The first expired tick only sets direction and enable.
                  dir_in = (cur_mode == MODE_REV);
                  en_in  = 1'b1;
               end else begin
                  out_in = ramp_out;
               end
            end
         end
         CMD_SET_MODE: begin
            if (in_range && q_mode_ff != MODE_BAD && q_mode_ff != cur_mode) begin
               acc_in    = 1'b1;
               mode_in   = q_mode_ff;
               delay_in  = en_delay_ff;
               target_in = '0;
               out_in    = '0;
               en_in     = 1'b0;
            end
         end
         CMD_SET_POWER: begin
            if (in_range && cur_mode != MODE_STOP) begin
               acc_in    = 1'b1;
               target_in = q_pwr_ff;
            end
         end
         default: acc_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PUMP_COUNT; i++) begin
            mode_ff[i]   <= MODE_STOP;
            delay_ff[i]  <= '0;
            target_ff[i] <= '0;
            out_ff[i]    <= '0;
            en_ff[i]     <= 1'b0;
            dir_ff[i]    <= 1'b0;
         end
      end else if (ctl.fire && in_range) begin
         mode_ff[sel]   <= mode_in;
         delay_ff[sel]  <= delay_in;
         target_ff[sel] <= target_in;
         out_ff[sel]    <= out_in;
         en_ff[sel]     <= en_in;
         dir_ff[sel]    <= dir_in;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.is_last  = (q_cmd_ff != CMD_TICK) || (ptr_ff == PTR_W'(PUMP_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         rsp_unit_ff   <= (q_cmd_ff == CMD_TICK) ? 4'(ptr_ff) : q_idx_ff;
         rsp_acc_ff    <= acc_in;
         rsp_mode_ff   <= in_range ? mode_in : MODE_STOP;
         rsp_target_ff <= in_range ? target_in : '0;
         rsp_drive_ff  <= in_range ? out_in : '0;
         rsp_en_ff     <= in_range && en_in;
         rsp_dir_ff    <= in_range && dir_in;
         rsp_last_ff   <= stat.is_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_unit         = rsp_unit_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_mode_now     = rsp_mode_ff;
   assign rsp_target_now   = rsp_target_ff;
   assign rsp_drive_level  = rsp_drive_ff;
   assign rsp_enable_line  = rsp_en_ff;
   assign rsp_reverse_line = rsp_dir_ff;
   assign rsp_last         = rsp_last_ff;

   `PPR_ASSERT(a_fire_needs_room, ctl.fire |-> stat.out_free,
               "result overwritten before it was taken")
   `PPR_ASSERT(a_drive_capped, rsp_valid_ff |-> rsp_drive_ff <= CEIL_LIMIT,
               "drive level above the ceiling")
   `PPR_ASSERT(a_stopped_disabled, rsp_valid_ff && rsp_mode_ff == MODE_STOP |-> !rsp_en_ff,
               "stopped pump reported as enabled")

endmodule

// ===== design/pump_power_ramp_controller_top.sv =====
// ----------------------------------------------------------------------------
// Pump power ramp controller
// Mode, target and slew-limited drive level for a small set of pump drivers.
// ----------------------------------------------------------------------------
// Usage: a request word on req_* is a set-mode, set-power or ramp-tick
// command. A set command returns one result word on rsp_* for the addressed
// pump; a tick visits every pump in index order and returns one word each,
// with rsp_last high on the final word of the request.
// Sequencing: the request is taken, then the sequencer updates one pump per
// cycle through a single shared update path while the result register is
// free, and takes the next request once the final word is loaded. The first
// result word is loaded once the sequencer runs and the result register can
// take it.
// Stalls: the result register holds its word while rsp_ready is low and the
// sequencer waits; the next request is taken while the final word waits.
// Configuration: csr_* writes a register and is always ready;
// write it only while the block is idle.
// Reset: all pumps stop with zero target, zero drive, enable low and
// direction forward; registers return to 700, 30 and 10.
// ----------------------------------------------------------------------------
module pump_power_ramp_controller_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [3:0] req_pump_index,
   input  logic [1:0] req_new_mode,
   input  logic [9:0] req_power_permil,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_unit,
   output logic       rsp_accepted,
   output logic [1:0] rsp_mode_now,
   output logic [9:0] rsp_target_now,
   output logic [9:0] rsp_drive_level,
   output logic       rsp_enable_line,
   output logic       rsp_reverse_line,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_data
);
   import ppr_pkg::*;

   ppr_ctl_type  ctl;
   ppr_stat_type stat;

   assign csr_ready = 1'b1;

   ppr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   ppr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_pump_index   (req_pump_index),
      .req_new_mode     (req_new_mode),
      .req_power_permil (req_power_permil),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_unit         (rsp_unit),
      .rsp_accepted     (rsp_accepted),
      .rsp_mode_now     (rsp_mode_now),
      .rsp_target_now   (rsp_target_now),
      .rsp_drive_level  (rsp_drive_level),
      .rsp_enable_line  (rsp_enable_line),
      .rsp_reverse_line (rsp_reverse_line),
      .rsp_last         (rsp_last)
   );

endmodule
